### design/packed_list_entry_parser_top_macros.svh
// Assertion macros shared by the packed list entry parser modules.
`ifndef PACKED_LIST_ENTRY_PARSER_TOP_MACROS_SVH
`define PACKED_LIST_ENTRY_PARSER_TOP_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define PLEP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define PLEP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/plep_pkg.sv
// Types, codes and helper functions of the packed list entry parser.
`timescale 1ns / 1ps
`default_nettype none

package plep_pkg;

	typedef enum logic [2:0] {
		PH_LEAD = 3'd0,
		PH_INT  = 3'd1,
		PH_LEN  = 3'd2,
		PH_DATA = 3'd3,
		PH_BACK = 3'd4
	} phase_t;

	typedef enum logic [3:0] {
		SEL_INT7  = 4'd0,
		SEL_INT13 = 4'd1,
		SEL_INT16 = 4'd2,
		SEL_INT24 = 4'd3,
		SEL_INT32 = 4'd4,
		SEL_INT64 = 4'd5,
		SEL_STR6  = 4'd6,
		SEL_STR12 = 4'd7,
		SEL_STR32 = 4'd8
	} enc_sel_t;

	typedef enum logic [1:0] {
		KIND_INT       = 2'd0,
		KIND_STR_BYTE  = 2'd1,
		KIND_STR_EMPTY = 2'd2,
		KIND_INVALID   = 2'd3
	} kind_t;

	localparam logic [7:0] LEAD_STR32 = 8'hF0;
	localparam logic [7:0] LEAD_INT16 = 8'hF1;
	localparam logic [7:0] LEAD_INT24 = 8'hF2;
	localparam logic [7:0] LEAD_INT32 = 8'hF3;
	localparam logic [7:0] LEAD_INT64 = 8'hF4;

	typedef struct packed {
		kind_t              kind;
		logic signed [63:0] int_value;
		logic [7:0]         data_byte;
		logic [31:0]        text_length;
		logic               last;
	} result_t;

	// Number of back-length bytes: one per 7-bit group of the entry size.
	function automatic logic [2:0] backlen_count(input logic [32:0] size);
		logic [2:0] n;
		if (size[32:28] != '0) begin
			n = 3'd5;
		end else if (size[27:21] != '0) begin
			n = 3'd4;
		end else if (size[20:14] != '0) begin
			n = 3'd3;
		end else if (size[13:7] != '0) begin
			n = 3'd2;
		end else begin
			n = 3'd1;
		end
		return n;
	endfunction

	function automatic logic [63:0] sign_extend(input logic [63:0] v, input enc_sel_t sel);
		logic [63:0] r;
		case (sel)
			SEL_INT7:  r = {{57{v[6]}}, v[6:0]};
			SEL_INT13: r = {{51{v[12]}}, v[12:0]};
			SEL_INT16: r = {{48{v[15]}}, v[15:0]};
			SEL_INT24: r = {{40{v[23]}}, v[23:0]};
			SEL_INT32: r = {{32{v[31]}}, v[31:0]};
			default:   r = v;
		endcase
		return r;
	endfunction

	function automatic logic [32:0] int_record_bytes(input enc_sel_t sel);
		logic [32:0] r;
		case (sel)
			SEL_INT7:  r = 33'd1;
			SEL_INT13: r = 33'd2;
			SEL_INT16: r = 33'd3;
			SEL_INT24: r = 33'd4;
			SEL_INT32: r = 33'd5;
			default:   r = 33'd9;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

### design/plep_if.sv
// Handshake interfaces for the byte input and the decoded result output.
`timescale 1ns / 1ps
`default_nettype none

interface plep_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source(output valid, output in_byte, input ready);
	modport sink(input valid, input in_byte, output ready);
endinterface

interface plep_out_if;
	logic               valid;
	logic               ready;
	logic [1:0]         result_kind;
	logic signed [63:0] int_value;
	logic [7:0]         data_byte;
	logic [31:0]        text_length;
	logic               last;

	modport source(output valid, output result_kind, output int_value, output data_byte,
		output text_length, output last, input ready);
	modport sink(input valid, input result_kind, input int_value, input data_byte,
		input text_length, input last, output ready);
endinterface

`default_nettype wire

### design/plep_core.sv
// Input register and per-byte entry decoding state machine.
`timescale 1ns / 1ps
`default_nettype none
`include "packed_list_entry_parser_top_macros.svh"

module plep_core (
	input  wire                 clk,
	input  wire                 arst_n,
	plep_in_if.sink             entry_area,
	input  wire                 full,
	output logic                res_valid,
	output plep_pkg::result_t   res
);

	logic                 valid_s1;
	logic [7:0]           byte_s1;
	logic                 advance;

	plep_pkg::phase_t     phase_q, phase_n;
	plep_pkg::enc_sel_t   sel_q, sel_n;
	logic [31:0]          bytes_left_q, bytes_left_n;
	logic [63:0]          accum_q, accum_n;
	logic [3:0]           shift_q, shift_n;
	logic [31:0]          str_len_q, str_len_n;
	logic [32:0]          entry_q, entry_n;
	logic [2:0]           backlen_q, backlen_n;

	assign advance = valid_s1 && !full;
	assign entry_area.ready = !valid_s1 || !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (entry_area.ready) begin
			valid_s1 <= entry_area.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (entry_area.valid && entry_area.ready) begin
			byte_s1 <= entry_area.in_byte;
		end
	end

	always_comb begin
		logic        str_go;
		logic [31:0] str_len_v;
		logic [32:0] str_header;
		logic        back_go;
		logic [32:0] back_size;
		logic [31:0] left_dec;

		phase_n      = phase_q;
		sel_n        = sel_q;
		bytes_left_n = bytes_left_q;
		accum_n      = accum_q;
		shift_n      = shift_q;
		str_len_n    = str_len_q;
		entry_n      = entry_q;
		backlen_n    = backlen_q;
		res_valid    = 1'b0;
		res          = '0;
		str_go       = 1'b0;
		str_len_v    = str_len_q;
		str_header   = '0;
		back_go      = 1'b0;
		back_size    = '0;
		left_dec     = (bytes_left_q != '0) ? bytes_left_q - 32'd1 : '0;

		if (advance) begin
			case (phase_q)
				plep_pkg::PH_INT: begin
					if (sel_q == plep_pkg::SEL_INT13) begin
						accum_n[7:0] = accum_q[7:0] | byte_s1;
					end else begin
						accum_n[{shift_q[2:0], 3'b000} +: 8] =
							accum_q[{shift_q[2:0], 3'b000} +: 8] | byte_s1;
						shift_n = shift_q + 4'd1;
					end
					bytes_left_n = left_dec;
					if (left_dec == '0) begin
						res_valid     = 1'b1;
						res.kind      = plep_pkg::KIND_INT;
						res.int_value = plep_pkg::sign_extend(accum_n, sel_q);
						res.last      = 1'b1;
						back_go       = 1'b1;
						back_size     = plep_pkg::int_record_bytes(sel_q);
					end
				end
				plep_pkg::PH_LEN: begin
					if (sel_q == plep_pkg::SEL_STR12) begin
						str_len_v[7:0] = str_len_q[7:0] | byte_s1;
						bytes_left_n   = '0;
						str_go         = 1'b1;
						str_header     = 33'd2;
					end else begin
						str_len_v[{shift_q[1:0], 3'b000} +: 8] =
							str_len_q[{shift_q[1:0], 3'b000} +: 8] | byte_s1;
						shift_n      = shift_q + 4'd1;
						bytes_left_n = left_dec;
						str_go       = (left_dec == '0);
						str_header   = 33'd5;
					end
					str_len_n = str_len_v;
				end
				plep_pkg::PH_DATA: begin
					bytes_left_n    = left_dec;
					res_valid       = 1'b1;
					res.kind        = plep_pkg::KIND_STR_BYTE;
					res.data_byte   = byte_s1;
					res.text_length = str_len_q;
					res.last        = (bytes_left_q <= 32'd1);
					if (bytes_left_q <= 32'd1) begin
						back_go   = 1'b1;
						back_size = entry_q;
					end
				end
				plep_pkg::PH_BACK: begin
					backlen_n = (backlen_q != '0) ? backlen_q - 3'd1 : '0;
					if (backlen_n == '0) begin
						phase_n = plep_pkg::PH_LEAD;
					end
				end
				default: begin
					phase_n = plep_pkg::PH_LEAD;
					accum_n = '0;
					shift_n = '0;
					if (!byte_s1[7]) begin
						sel_n         = plep_pkg::SEL_INT7;
						res_valid     = 1'b1;
						res.kind      = plep_pkg::KIND_INT;
						res.int_value = {56'd0, byte_s1};
						res.last      = 1'b1;
						back_go       = 1'b1;
						back_size     = 33'd1;
					end else if (byte_s1[7:5] == 3'b110) begin
						sel_n        = plep_pkg::SEL_INT13;
						accum_n      = {51'd0, byte_s1[4:0], 8'd0};
						bytes_left_n = 32'd1;
						phase_n      = plep_pkg::PH_INT;
					end else if (byte_s1 == plep_pkg::LEAD_INT16) begin
						sel_n        = plep_pkg::SEL_INT16;
						bytes_left_n = 32'd2;
						phase_n      = plep_pkg::PH_INT;
					end else if (byte_s1 == plep_pkg::LEAD_INT24) begin
						sel_n        = plep_pkg::SEL_INT24;
						bytes_left_n = 32'd3;
						phase_n      = plep_pkg::PH_INT;
					end else if (byte_s1 == plep_pkg::LEAD_INT32) begin
						sel_n        = plep_pkg::SEL_INT32;
						bytes_left_n = 32'd4;
						phase_n      = plep_pkg::PH_INT;
					end else if (byte_s1 == plep_pkg::LEAD_INT64) begin
						sel_n        = plep_pkg::SEL_INT64;
						bytes_left_n = 32'd8;
						phase_n      = plep_pkg::PH_INT;
					end else if (byte_s1[7:6] == 2'b10) begin
						sel_n      = plep_pkg::SEL_STR6;
						str_len_v  = {26'd0, byte_s1[5:0]};
						str_len_n  = str_len_v;
						str_go     = 1'b1;
						str_header = 33'd1;
					end else if (byte_s1[7:4] == 4'b1110) begin
						sel_n        = plep_pkg::SEL_STR12;
						str_len_n    = {20'd0, byte_s1[3:0], 8'd0};
						bytes_left_n = 32'd1;
						phase_n      = plep_pkg::PH_LEN;
					end else if (byte_s1 == plep_pkg::LEAD_STR32) begin
						sel_n        = plep_pkg::SEL_STR32;
						str_len_n    = '0;
						bytes_left_n = 32'd4;
						phase_n      = plep_pkg::PH_LEN;
					end else begin
						res_valid = 1'b1;
						res.kind  = plep_pkg::KIND_INVALID;
						res.last  = 1'b1;
					end
				end
			endcase

			// The string length is known: either an empty marker or the payload follows.
			if (str_go) begin
				if (str_len_v == '0) begin
					res_valid = 1'b1;
					res.kind  = plep_pkg::KIND_STR_EMPTY;
					res.last  = 1'b1;
					back_go   = 1'b1;
					back_size = str_header;
				end else begin
					entry_n      = {1'b0, str_len_v} + str_header;
					bytes_left_n = str_len_v;
					phase_n      = plep_pkg::PH_DATA;
				end
			end

			if (back_go) begin
				entry_n   = back_size;
				backlen_n = plep_pkg::backlen_count(back_size);
				phase_n   = plep_pkg::PH_BACK;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= plep_pkg::PH_LEAD;
			sel_q        <= plep_pkg::SEL_INT7;
			bytes_left_q <= '0;
			accum_q      <= '0;
			shift_q      <= '0;
			str_len_q    <= '0;
			entry_q      <= '0;
			backlen_q    <= '0;
		end else begin
			phase_q      <= phase_n;
			sel_q        <= sel_n;
			bytes_left_q <= bytes_left_n;
			accum_q      <= accum_n;
			shift_q      <= shift_n;
			str_len_q    <= str_len_n;
			entry_q      <= entry_n;
			backlen_q    <= backlen_n;
		end
	end

	`PLEP_ASSERT_SAME(a_back_nonzero, clk, arst_n, phase_q == plep_pkg::PH_BACK, backlen_q != 3'd0, "Back-length phase with no bytes left to skip.")
	`PLEP_ASSERT_SAME(a_single_last, clk, arst_n, res_valid && res.kind != plep_pkg::KIND_STR_BYTE, res.last, "Single-result entry not marked as last.")
	`PLEP_ASSERT_SAME(a_no_push_full, clk, arst_n, full, !res_valid, "Result produced while the output buffer is full.")

endmodule

`default_nettype wire

### design/plep_out_buf.sv
// Two-entry output buffer that decouples the decoder from a stalling receiver.
`timescale 1ns / 1ps
`default_nettype none
`include "packed_list_entry_parser_top_macros.svh"

module plep_out_buf (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	input  wire plep_pkg::result_t push_data,
	output logic                full,
	plep_out_if.source          decoded
);

	logic [1:0]        count_q;
	plep_pkg::result_t head_q;
	plep_pkg::result_t tail_q;
	logic              pop;

	assign pop  = decoded.valid && decoded.ready;
	assign full = (count_q == 2'd2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push && !pop) begin
			if (count_q == 2'd0) begin
				head_q <= push_data;
			end else begin
				tail_q <= push_data;
			end
		end else if (pop && !push) begin
			head_q <= tail_q;
		end else if (pop && push) begin
			if (count_q == 2'd1) begin
				head_q <= push_data;
			end else begin
				head_q <= tail_q;
				tail_q <= push_data;
			end
		end
	end

	assign decoded.valid       = (count_q != 2'd0);
	assign decoded.result_kind = head_q.kind;
	assign decoded.int_value   = head_q.int_value;
	assign decoded.data_byte   = head_q.data_byte;
	assign decoded.text_length = head_q.text_length;
	assign decoded.last        = head_q.last;

	`PLEP_ASSERT_SAME(a_count_range, clk, arst_n, 1'b1, count_q != 2'd3, "Output buffer count out of range.")
	`PLEP_ASSERT_NEXT(a_full_holds, clk, arst_n, full && !decoded.ready, full, "Full buffer lost a request while stalled.")

endmodule

`default_nettype wire

### design/packed_list_entry_parser_top.sv
// Packed list entry parser: the byte input register, the decoder and the output buffer.
// The entry_area channel takes the entry area one byte per request, in forward order,
// beginning with the lead byte of an entry. The decoded channel returns at most one
// request per byte: a whole sign-extended integer, one string payload byte with the
// string length, an empty-string marker, or an invalid-lead marker; last marks the
// final request of each entry. Length bytes and trailing back-length bytes give none.
// A byte is registered at acceptance and decoded from that input register, while the
// output buffer is not full, into a two-entry output buffer from which results are taken.
// One byte is accepted every cycle unless the buffer is full and the input register holds a byte.
// When the receiver stalls, the buffer fills and input ready drops only once both
// buffer entries and the input register hold work; ready does not depend
// combinationally on the receiver's ready. Reset is asynchronous and active low:
// it empties the input register and the buffer and leaves the decoder waiting for
// a lead byte.
`timescale 1ns / 1ps
`default_nettype none

module packed_list_entry_parser_top (
	input  wire         clk,
	input  wire         arst_n,
	plep_in_if.sink     entry_area,
	plep_out_if.source  decoded
);

	logic              res_valid;
	plep_pkg::result_t res;
	logic              full;

	plep_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.entry_area (entry_area),
		.full       (full),
		.res_valid  (res_valid),
		.res        (res)
	);

	plep_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.full      (full),
		.decoded   (decoded)
	);

endmodule

`default_nettype wire
